// ----- rtl/bdll_pkg.sv -----
// Shared types and constants for the bounded doubly linked list.
package bdll_pkg;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0,
    MODE_PUSH_HEAD = 3'd1,
    MODE_POP_TAIL = 3'd2,
    MODE_POP_HEAD = 3'd3,
    MODE_SEARCH = 3'd4,
    MODE_DELETE = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INSERT,
    S_WALK_RD,
    S_WALK_CHK,
    S_UNLINK,
    S_UNLINK_P,
    S_UNLINK_N,
    S_DONE
  } state_t;
endpackage

// ----- rtl/bounded_doubly_linked_list.sv -----
// Bounded doubly linked list: deque with search and delete by value.
// Full or empty answers go straight to the done state; inserts write the new node and
// may then patch a neighbor's link; removal and search/delete read nodes from the node
// memory, a read state then a check state per node. One command at a time: busy is high from
// the cycle after start until the result strobe, and the receiver cannot stall.
// Synchronous active-low reset empties the list and refills the free stack at once.
module bounded_doubly_linked_list import bdll_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_mode,
  input  logic signed [31:0] in_value,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic              out_found,
  output logic signed [31:0] out_removed_value,
  output logic [4:0]        out_element_count
);
  localparam int IW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  state_t state_r, state_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [LW-1:0] head_r, head_nxt, tail_r, tail_nxt, cnt_r, cnt_nxt;
  logic [LW-1:0] fcnt_r, fcnt_nxt, cur_r, cur_nxt, steps_r, steps_nxt;
  logic [LW-1:0] pl_r, pl_nxt, nl_r, nl_nxt;
  logic [IW-1:0] fstk_r [CAPACITY];
  logic [IW-1:0] node_r, node_nxt;
  logic [1:0] st_r, st_nxt;
  logic fnd_r, fnd_nxt, ov_r, ov_nxt, push_free;
  logic signed [31:0] rem_r, rem_nxt;

  logic rd_en, wv_en, wn_en, wp_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic signed [31:0] rd_value, wr_value;
  logic [LW-1:0] rd_next, rd_prev, wr_next, wr_prev;

  bdll_node_mem #(.CAPACITY(CAPACITY), .IW(IW), .LW(LW)) u_mem (
    .clk, .rd_en, .rd_addr, .rd_value, .rd_next, .rd_prev,
    .wv_en, .wn_en, .wp_en, .wr_addr, .wr_value, .wr_next, .wr_prev
  );

  logic empty;
  assign empty = (head_r == NIL) || (cnt_r == '0);

  always_comb begin
    state_nxt = state_r; mode_nxt = mode_r; val_nxt = val_r;
    head_nxt = head_r; tail_nxt = tail_r; cnt_nxt = cnt_r; fcnt_nxt = fcnt_r;
    cur_nxt = cur_r; steps_nxt = steps_r; pl_nxt = pl_r; nl_nxt = nl_r;
    node_nxt = node_r; st_nxt = st_r; fnd_nxt = fnd_r; rem_nxt = rem_r;
    ov_nxt = 1'b0; push_free = 1'b0;
    rd_en = 1'b0; rd_addr = '0; wv_en = 1'b0; wn_en = 1'b0; wp_en = 1'b0;
    wr_addr = '0; wr_value = val_r; wr_next = NIL; wr_prev = NIL;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt = in_mode; val_nxt = in_value;
          st_nxt = ST_OK; fnd_nxt = 1'b0; rem_nxt = '0;
          case (in_mode)
            MODE_APPEND, MODE_PUSH_HEAD: begin
              if (fcnt_r == '0 || cnt_r >= NIL) begin
                st_nxt = ST_FULL; state_nxt = S_DONE;
              end else begin
                node_nxt = fstk_r[IW'(fcnt_r - 1'b1)];
                fcnt_nxt = fcnt_r - 1'b1;
                state_nxt = S_INSERT;
              end
            end
            MODE_POP_TAIL, MODE_POP_HEAD, MODE_SEARCH, MODE_DELETE: begin
              if (empty) begin
                st_nxt = ST_EMPTY; state_nxt = S_DONE;
              end else if (in_mode == MODE_POP_TAIL) begin
                if (tail_r == NIL) state_nxt = S_DONE;
                else begin
                  cur_nxt = tail_r; state_nxt = S_WALK_RD;
                end
              end else begin
                cur_nxt = head_r; steps_nxt = '0; state_nxt = S_WALK_RD;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_INSERT: begin
        // write the new node, patch one neighbor's link if the list was not empty
        wv_en = 1'b1; wn_en = 1'b1; wp_en = 1'b1; wr_addr = node_r;
        if (empty) begin
          head_nxt = LW'(node_r); tail_nxt = LW'(node_r);
          state_nxt = S_DONE;
        end else if (mode_r == MODE_APPEND) begin
          wr_prev = tail_r; tail_nxt = LW'(node_r);
          pl_nxt = tail_r;
          state_nxt = (tail_r == NIL) ? S_DONE : S_UNLINK_P;
          nl_nxt = LW'(node_r);
        end else begin
          wr_next = head_r; head_nxt = LW'(node_r);
          nl_nxt = head_r; pl_nxt = LW'(node_r);
          state_nxt = S_UNLINK_N;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      S_WALK_RD: begin
        rd_en = 1'b1; rd_addr = IW'(cur_r); state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        node_nxt = IW'(cur_r); pl_nxt = rd_prev; nl_nxt = rd_next;
        if (mode_r == MODE_POP_TAIL || mode_r == MODE_POP_HEAD) begin
          state_nxt = S_UNLINK;
        end else if (rd_value == val_r) begin
          fnd_nxt = 1'b1;
          state_nxt = (mode_r == MODE_DELETE) ? S_UNLINK : S_DONE;
        end else if (steps_r + 1'b1 >= NIL || rd_next >= NIL) begin
          st_nxt = ST_NOT_FOUND; state_nxt = S_DONE;
        end else begin
          steps_nxt = steps_r + 1'b1; cur_nxt = rd_next; state_nxt = S_WALK_RD;
        end
      end
      S_UNLINK: begin
        rem_nxt = rd_value; push_free = 1'b1;
        if (fcnt_r < NIL) fcnt_nxt = fcnt_r + 1'b1;
        if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
        if (pl_r >= NIL) head_nxt = nl_r;
        if (nl_r >= NIL) tail_nxt = pl_r;
        state_nxt = (pl_r < NIL) ? S_UNLINK_P : ((nl_r < NIL) ? S_UNLINK_N : S_DONE);
      end
      S_UNLINK_P: begin
        // next_link[prev] = next
        wn_en = 1'b1; wr_addr = IW'(pl_r); wr_next = nl_r;
        state_nxt = (nl_r < NIL && mode_r != MODE_APPEND) ? S_UNLINK_N : S_DONE;
      end
      S_UNLINK_N: begin
        wp_en = 1'b1; wr_addr = IW'(nl_r); wr_prev = pl_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; head_r <= NIL; tail_r <= NIL; cnt_r <= '0;
      fcnt_r <= NIL; ov_r <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) fstk_r[i] <= IW'(i);
    end else begin
      state_r <= state_nxt; head_r <= head_nxt; tail_r <= tail_nxt;
      cnt_r <= cnt_nxt; fcnt_r <= fcnt_nxt; ov_r <= ov_nxt;
      if (push_free && fcnt_r < NIL) fstk_r[IW'(fcnt_r)] <= node_r;
    end
    mode_r <= mode_nxt; val_r <= val_nxt; cur_r <= cur_nxt; steps_r <= steps_nxt;
    pl_r <= pl_nxt; nl_r <= nl_nxt; node_r <= node_nxt; st_r <= st_nxt;
    fnd_r <= fnd_nxt; rem_r <= rem_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_found = fnd_r;
  assign out_removed_value = rem_r;
  assign out_element_count = 5'(cnt_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NIL) else $error("count above capacity");
  a_pool: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> cnt_r + fcnt_r == NIL) else $error("node pool leak");
  a_empty_nil: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cnt_r == '0) |-> (head_r == NIL && tail_r == NIL))
    else $error("empty list keeps links");
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK) else $error("found with error");
endmodule

// ----- rtl/bdll_node_mem.sv -----
// Node store: value, next and prev links in three synchronous arrays with shared addresses.
module bdll_node_mem import bdll_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IW = $clog2(CAPACITY),
  parameter int LW = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [IW-1:0]       rd_addr,
  output logic signed [31:0]  rd_value,
  output logic [LW-1:0]       rd_next,
  output logic [LW-1:0]       rd_prev,
  input  logic                wv_en,
  input  logic                wn_en,
  input  logic                wp_en,
  input  logic [IW-1:0]       wr_addr,
  input  logic signed [31:0]  wr_value,
  input  logic [LW-1:0]       wr_next,
  input  logic [LW-1:0]       wr_prev
);
  logic signed [31:0] val_mem [CAPACITY];
  logic [LW-1:0] nxt_mem [CAPACITY];
  logic [LW-1:0] prv_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wv_en) val_mem[wr_addr] <= wr_value;
    if (wn_en) nxt_mem[wr_addr] <= wr_next;
    if (wp_en) prv_mem[wr_addr] <= wr_prev;
    if (rd_en) begin
      rd_value <= val_mem[rd_addr];
      rd_next <= nxt_mem[rd_addr];
      rd_prev <= prv_mem[rd_addr];
    end
  end
endmodule

// ----- bench/tb.sv -----
// Testbench for the bounded doubly linked list: predicts every command's result.
module tb;
  import bdll_pkg::*;

  localparam int CAP = 16;
  localparam logic [4:0] NIL = 5'(CAP);

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] removed_value;
    logic [4:0]  element_count;
  } list_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        in_mode = '0;
  logic signed [31:0] in_value = '0;
  logic              out_valid;
  logic [1:0]        out_status;
  logic              out_found;
  logic signed [31:0] out_removed_value;
  logic [4:0]        out_element_count;

  // Predictor state
  logic [31:0] pool_value [CAP];
  logic [4:0]  pool_next [CAP];
  logic [4:0]  pool_prev [CAP];
  logic [4:0]  head_q, tail_q;
  int          length_q;
  logic [3:0]  free_nodes [CAP];
  int          free_top;

  list_result_t expected_results [$];
  int          errors = 0;
  bit          sender_idle = 1'b1;

  bounded_doubly_linked_list #(.CAPACITY(CAP)) i_dut (
    .clk, .rst_n, .start, .busy, .in_mode, .in_value, .out_valid, .out_status,
    .out_found, .out_removed_value, .out_element_count
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] unlink_node(input logic [4:0] n);
    logic [4:0] p, s;
    p = pool_prev[n];
    s = pool_next[n];
    if (p < NIL) pool_next[p] = s; else head_q = s;
    if (s < NIL) pool_prev[s] = p; else tail_q = p;
    free_nodes[free_top] = n[3:0];
    free_top++;
    length_q--;
    return pool_value[n];
  endfunction

  function automatic list_result_t predict_command(input logic [2:0] mode,
                                                   input logic [31:0] value);
    list_result_t r;
    logic [4:0] n, cur;
    logic [4:0] hit;
    r = '0;
    hit = NIL;
    case (mode)
      MODE_APPEND, MODE_PUSH_HEAD: begin
        if (length_q >= CAP) r.status = ST_FULL;
        else begin
          free_top--;
          n = {1'b0, free_nodes[free_top]};
          pool_value[n] = value;
          if (length_q == 0) begin
            pool_next[n] = NIL; pool_prev[n] = NIL; head_q = n; tail_q = n;
          end else if (mode == MODE_APPEND) begin
            pool_next[n] = NIL; pool_prev[n] = tail_q; pool_next[tail_q] = n; tail_q = n;
          end else begin
            pool_prev[n] = NIL; pool_next[n] = head_q; pool_prev[head_q] = n; head_q = n;
          end
          length_q++;
        end
      end
      MODE_POP_TAIL, MODE_POP_HEAD, MODE_SEARCH, MODE_DELETE: begin
        if (length_q == 0) r.status = ST_EMPTY;
        else if (mode == MODE_POP_TAIL) r.removed_value = unlink_node(tail_q);
        else if (mode == MODE_POP_HEAD) r.removed_value = unlink_node(head_q);
        else begin
          cur = head_q;
          for (int k = 0; k < CAP && cur < NIL && hit == NIL; k++) begin
            if (pool_value[cur] == value) hit = cur;
            else cur = pool_next[cur];
          end
          if (hit == NIL) r.status = ST_NOT_FOUND;
          else begin
            r.found = 1'b1;
            if (mode == MODE_DELETE) r.removed_value = unlink_node(hit);
          end
        end
      end
      default: ;
    endcase
    r.element_count = 5'(length_q);
    return r;
  endfunction

  // Send one command; hold start until the transaction is taken.
  task automatic send_command(input logic [2:0] mode, input logic [31:0] value);
    int gap;
    if (!sender_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_value <= value;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_command(mode, value));
    start <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) report("unexpected result", '0, '0);
      else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) report("status", out_status, want.status);
        if (out_found !== want.found) report("found", out_found, want.found);
        if (out_removed_value !== want.removed_value)
          report("removed_value", out_removed_value, want.removed_value);
        if (out_element_count !== want.element_count)
          report("element_count", out_element_count, want.element_count);
      end
    end
  end

  function automatic logic [31:0] pick_value();
    // Mostly a small alphabet so that search and delete hit often.
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      default: return $urandom_range(0, 7) - 4;
    endcase
  endfunction

  task automatic test_directed();
    send_command(MODE_POP_TAIL, 0);
    send_command(MODE_POP_HEAD, 0);
    send_command(MODE_SEARCH, 5);
    send_command(MODE_DELETE, 5);
    send_command(MODE_APPEND, 32'h7fff_ffff);
    send_command(MODE_POP_HEAD, 0);
    send_command(MODE_PUSH_HEAD, 32'h8000_0000);
    send_command(MODE_POP_TAIL, 0);
    for (int k = 0; k < 16; k++)
      send_command(k[0] ? MODE_PUSH_HEAD : MODE_APPEND, k);
    send_command(MODE_APPEND, 32'hffff_ffff);
    send_command(MODE_PUSH_HEAD, 32'h5555_aaaa);
    send_command(MODE_SEARCH, 14);
    send_command(MODE_SEARCH, 99);
    send_command(MODE_DELETE, 14);
    send_command(MODE_DELETE, 99);
    send_command(3'd6, 1);
    send_command(3'd7, 2);
  endtask

  task automatic test_random(input int count, input bit with_gaps);
    int r;
    logic [2:0] mode;
    sender_idle = !with_gaps;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 22) mode = MODE_APPEND;
      else if (r < 40) mode = MODE_PUSH_HEAD;
      else if (r < 52) mode = MODE_POP_TAIL;
      else if (r < 64) mode = MODE_POP_HEAD;
      else if (r < 80) mode = MODE_SEARCH;
      else if (r < 97) mode = MODE_DELETE;
      else mode = 3'($urandom_range(6, 7));
      send_command(mode, pick_value());
    end
  endtask

  task automatic test_drain_full();
    sender_idle = 1'b1;
    for (int k = 0; k < 20; k++) send_command(MODE_POP_TAIL, 0);
    for (int k = 0; k < 18; k++) send_command(MODE_APPEND, $urandom);
  endtask

  initial begin
    head_q = NIL; tail_q = NIL; length_q = 0; free_top = CAP;
    for (int k = 0; k < CAP; k++) free_nodes[k] = 4'(k);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1300, 1'b1);
    test_drain_full();
    test_random(100, 1'b0);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * CAP + 10) @(posedge clk);
    if (errors == 0) $display("bounded_doubly_linked_list: match");
    else $display("bounded_doubly_linked_list: mismatch");
    $finish;
  end

  initial begin
    #5000000;
    $display("bounded_doubly_linked_list: mismatch");
    $finish;
  end
endmodule
